[src/esde_pkg.sv]
// ============================================================================
// esde_pkg
// Shared widths, constants, codes and types of the encoder speed and
// direction estimator.
// ============================================================================
package esde_pkg;

    // Field and port widths
    localparam int SPEED_W      = 12;
    localparam int DIR_W        = 2;
    localparam int TURN_BITS_W  = 6;
    localparam int PERIOD_W     = 5;
    localparam int DEAD_BAND_W  = 16;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 16;

    // Defaults of the top-level parameters
    localparam int POSITION_WIDTH_DEF = 32;
    localparam int CONFIRM_COUNT_DEF  = 3;

    // Speed scaling: rpm = |diff| * 60000 / (period * 10 * 2^bits)
    localparam int MS_PER_MIN   = 60000;
    localparam int TENS_MS      = 10;
    localparam int RPM_SCALE    = MS_PER_MIN / TENS_MS;
    localparam int RPM_SCALE_W  = 13;
    localparam int RPM_MAX      = 3000;
    localparam int PERIOD_MAX   = 20;
    localparam int HIST_DEPTH   = 3;
    localparam int SLOT_W       = 2;

    // Register reset values
    localparam int TURN_BITS_RST = 12;
    localparam int PERIOD_RST    = 1;
    localparam int DEAD_BAND_RST = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_TURN_BITS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DEAD_BAND = 2'd2;

    // Direction codes
    typedef enum logic [DIR_W-1:0] {
        DIR_STOP = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2
    } dir_t;

    // Sequencer states of the top level
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MUL,
        ST_SCALE,
        ST_DIV,
        ST_HIST,
        ST_FINISH
    } state_t;

    // Status of the serial divider
    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

[src/esde_serial_div.sv]
// ============================================================================
// esde_serial_div
// Restoring divider that takes one quotient bit per cycle: a speed value is
// divided by the sample period in one restoring step per bit of the speed.
// ============================================================================
module esde_serial_div
    import esde_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [SPEED_W-1:0]  dividend,
    input  logic [PERIOD_W-1:0] divisor,
    output div_sts_t            sts,
    output logic [SPEED_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(SPEED_W + 1);

    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [PERIOD_W-1:0] rem_reg;
    logic [SPEED_W-1:0]  quo_reg;

    logic [PERIOD_W:0]   trial;
    logic                fits;
    logic [PERIOD_W:0]   trial_diff;
    logic [PERIOD_W-1:0] rem_next;

    // One restoring step: bring down the next dividend bit and try the divisor.
    always_comb
    begin
        trial      = {rem_reg, quo_reg[SPEED_W-1]};
        fits       = (trial >= {1'b0, divisor});
        trial_diff = trial - {1'b0, divisor};
        rem_next   = fits ? trial_diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
    end

    // Step counter and status.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(SPEED_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // The dividend shifts out at the top while quotient bits shift in below.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[SPEED_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quotient = quo_reg;

endmodule

[src/encoder_speed_direction_estimator_core.sv]
// ============================================================================
// encoder_speed_direction_estimator_core
// Turns single-turn position samples into a median-filtered speed in rpm and
// a qualified direction of rotation.
// ============================================================================
//
//  Channel  Signals                          Beat carries
//  -------  -------------------------------  --------------------------------
//  s_axis   s_axis_tvalid/tready/tdata[31:0] turn_position
//  m_axis   m_axis_tvalid/tready/tdata[15:0] speed_rpm, rot_dir
//  cfg      cfg_valid/ready/index/data       register write, always taken
//
//  A sample runs from its beat through the difference, multiply, scale,
//  divide, history and finish steps; the 12-step serial divider by the
//  sample period takes the most time. The first sample after reset only
//  primes the stored position and goes from difference straight to finish.
//  Reset clears the registers to 12 turn bits, period 1, dead band 2.
//  A finished result waits in the output register, and the next sample is
//  taken meanwhile; a result stalls in the last step only if the previous
//  one is still untaken.
//
module encoder_speed_direction_estimator_core
    import esde_pkg::*;
#(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
    parameter int CONFIRM_COUNT  = CONFIRM_COUNT_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Position input
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [31:0] turn_position
    // Speed and direction output
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [11:0] speed_rpm, [13:12] rot_dir
    // Configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int PW     = POSITION_WIDTH;
    localparam int BITS_W = $clog2(PW + 1);
    localparam int CNT_W  = $clog2(CONFIRM_COUNT + 1);
    localparam int PROD_W = PW + RPM_SCALE_W;
    localparam int CMP_W  = (PW > DEAD_BAND_W) ? PW : DEAD_BAND_W;

    // Configuration registers
    logic [TURN_BITS_W-1:0] turn_bits_reg;
    logic [PERIOD_W-1:0]    period_reg;
    logic [DEAD_BAND_W-1:0] dead_band_reg;

    // Sequencer
    state_t state_reg;
    state_t state_next;
    logic   div_start;
    logic   load_out;

    // Tracking state
    logic                  primed_reg;
    logic [PW-1:0]         prev_pos_reg;
    dir_t                  prev_class_reg;
    logic [CNT_W-1:0]      same_cnt_reg;
    dir_t                  held_dir_reg;
    logic [SPEED_W-1:0]    hist_reg [HIST_DEPTH];
    logic [SLOT_W-1:0]     slot_reg;

    // Per-sample working registers
    logic                  prime_reg;
    logic [PW-1:0]         cur_reg;
    logic [PW-1:0]         mag_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [SPEED_W-1:0]    rpm_reg;

    // Output register
    logic                  out_valid_reg;
    logic [SPEED_W-1:0]    out_speed_reg;
    dir_t                  out_dir_reg;

    // Combinational datapath
    logic [TURN_BITS_W-1:0] bits_wide;
    logic [BITS_W-1:0]      bits_eff;
    logic [PERIOD_W-1:0]    period_eff;
    logic [PW-1:0]          pos_mask;
    logic [PW-1:0]          half_turn;
    logic [PW-1:0]          prev_m;
    logic [PW-1:0]          diff_mod;
    logic                   diff_neg;
    logic [PW-1:0]          mag;
    dir_t                   cls;
    logic [CNT_W-1:0]       same_cnt_new;
    logic [PROD_W-1:0]      prod_scaled;
    logic [SPEED_W-1:0]     median;
    div_sts_t               div_sts;
    logic [SPEED_W-1:0]     div_quotient;

    // Middle value of three.
    function automatic logic [SPEED_W-1:0] median3(
        input logic [SPEED_W-1:0] a,
        input logic [SPEED_W-1:0] b,
        input logic [SPEED_W-1:0] c
    );
        logic [SPEED_W-1:0] lo_ab;
        logic [SPEED_W-1:0] hi_ab;
        logic [SPEED_W-1:0] lo_hc;
        begin
            lo_ab = (a < b) ? a : b;
            hi_ab = (a < b) ? b : a;
            lo_hc = (hi_ab < c) ? hi_ab : c;
            median3 = (lo_ab > lo_hc) ? lo_ab : lo_hc;
        end
    endfunction

    // Effective resolution, period and the masks that follow from them.
    always_comb
    begin
        if (turn_bits_reg == '0)
            bits_wide = TURN_BITS_W'(1);
        else if (turn_bits_reg > TURN_BITS_W'(PW))
            bits_wide = TURN_BITS_W'(PW);
        else
            bits_wide = turn_bits_reg;
        bits_eff = bits_wide[BITS_W-1:0];

        if (period_reg == '0 || period_reg > PERIOD_W'(PERIOD_MAX))
            period_eff = PERIOD_W'(1);
        else
            period_eff = period_reg;

        pos_mask  = ~({PW{1'b1}} << bits_eff);
        half_turn = PW'(1) << (bits_eff - 1'b1);
    end

    // Wrapped difference, its sign and magnitude, and the dead-band class.
    always_comb
    begin
        prev_m   = prev_pos_reg & pos_mask;
        diff_mod = (cur_reg - prev_m) & pos_mask;
        // Exactly half a turn keeps the sign of the unwrapped difference.
        diff_neg = (diff_mod > half_turn)
                   || ((diff_mod == half_turn) && !(cur_reg > prev_m));
        mag      = diff_neg ? ((~diff_mod + 1'b1) & pos_mask) : diff_mod;

        if (CMP_W'(mag) > CMP_W'(dead_band_reg))
            cls = diff_neg ? DIR_CCW : DIR_CW;
        else
            cls = DIR_STOP;

        if (cls != prev_class_reg)
            same_cnt_new = '0;
        else if (same_cnt_reg < CNT_W'(CONFIRM_COUNT))
            same_cnt_new = same_cnt_reg + 1'b1;
        else
            same_cnt_new = same_cnt_reg;
    end

    // Speed scaled to a whole turn, then the filtered value.
    assign prod_scaled = prod_reg >> bits_eff;
    assign median      = median3(hist_reg[0], hist_reg[1], hist_reg[2]);

    // Next state.
    always_comb
    begin
        case (state_reg)
            ST_IDLE:   state_next = s_axis_tvalid ? ST_DIFF : ST_IDLE;
            ST_DIFF:   state_next = prime_reg ? ST_FINISH : ST_MUL;
            ST_MUL:    state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_DIV;
            ST_DIV:    state_next = div_sts.done ? ST_HIST : ST_DIV;
            ST_HIST:   state_next = ST_FINISH;
            ST_FINISH: state_next = (!out_valid_reg || m_axis_tready) ? ST_IDLE : ST_FINISH;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        div_start     = (state_reg == ST_SCALE);
        load_out      = (state_reg == ST_FINISH) && (!out_valid_reg || m_axis_tready);
    end

    // Configuration registers; writes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_bits_reg <= TURN_BITS_W'(TURN_BITS_RST);
            period_reg    <= PERIOD_W'(PERIOD_RST);
            dead_band_reg <= DEAD_BAND_W'(DEAD_BAND_RST);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TURN_BITS: turn_bits_reg <= cfg_data[TURN_BITS_W-1:0];
                REG_PERIOD:    period_reg    <= cfg_data[PERIOD_W-1:0];
                REG_DEAD_BAND: dead_band_reg <= cfg_data[DEAD_BAND_W-1:0];
                default:       ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // Sequencer, tracking state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            primed_reg     <= 1'b0;
            prev_pos_reg   <= '0;
            prev_class_reg <= DIR_STOP;
            same_cnt_reg   <= '0;
            held_dir_reg   <= DIR_STOP;
            for (int i = 0; i < HIST_DEPTH; i++)
                hist_reg[i] <= '0;
            slot_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == ST_DIFF)
            begin
                prev_pos_reg <= cur_reg;
                if (prime_reg)
                begin
                    primed_reg   <= 1'b1;
                    held_dir_reg <= DIR_STOP;
                end
                else
                begin
                    prev_class_reg <= cls;
                    same_cnt_reg   <= same_cnt_new;
                    if (same_cnt_new >= CNT_W'(CONFIRM_COUNT))
                        held_dir_reg <= cls;
                end
            end

            // Ring of three raw speeds.
            if (state_reg == ST_HIST)
            begin
                hist_reg[slot_reg] <= rpm_reg;
                if (slot_reg >= SLOT_W'(HIST_DEPTH - 1))
                    slot_reg <= '0;
                else
                    slot_reg <= slot_reg + 1'b1;
            end

            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Working registers and output payload.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            cur_reg   <= s_axis_tdata[PW-1:0] & pos_mask;
            prime_reg <= !primed_reg;
        end
        if (state_reg == ST_DIFF)
            mag_reg <= mag;
        if (state_reg == ST_MUL)
            prod_reg <= PROD_W'(mag_reg) * PROD_W'(RPM_SCALE);
        if (state_reg == ST_DIV && div_sts.done)
            rpm_reg <= div_quotient;
        if (load_out)
        begin
            out_speed_reg <= prime_reg ? '0 : median;
            out_dir_reg   <= prime_reg ? DIR_STOP : held_dir_reg;
        end
    end

    // Divide the scaled speed by the sample period.
    esde_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_scaled[SPEED_W-1:0]),
        .divisor  (period_eff),
        .sts      (div_sts),
        .quotient (div_quotient)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - SPEED_W - DIR_W){1'b0}}, out_dir_reg, out_speed_reg};

`ifndef NO_ASSERTIONS
    // A reported speed never exceeds half a turn per minimum period.
    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[SPEED_W-1:0] <= SPEED_W'(RPM_MAX)))
        else $error("speed above its maximum");

    // While waiting on the divider, it is working or has just finished.
    a_div_alive: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (div_sts.busy || div_sts.done))
        else $error("waiting on an idle divider");

    // Any accepted sample leaves the block primed once its difference step is done.
    a_primed: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |-> ##2 primed_reg)
        else $error("sample did not prime the block");

    // The priming sample answers zero speed and standstill.
    a_prime_out: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && prime_reg) |=> (out_speed_reg == '0 && out_dir_reg == DIR_STOP))
        else $error("priming result not zero");

    // A finished result is held back while the previous one is untaken.
    a_out_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_valid_reg && !m_axis_tready)
        |=> (state_reg == ST_FINISH))
        else $error("result overwrote an untaken beat");
`endif

endmodule

[tb/tb_top.sv]
// ============================================================================
// tb_top
// Self-checking testbench of the encoder speed and direction estimator. A
// scoreboard predicts speed and direction for every accepted position beat
// and checks each result beat against the oldest prediction. A short directed
// part is followed by random motion sequences under changing register
// settings and changing back-pressure on both streams.
// ============================================================================
module tb_top;
    import esde_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int DRAIN_CYCLES = 24;
    localparam int STALL_LIMIT  = 4000;
    localparam int PHASE_ITEMS  = 450;

    // The last register index is not mapped to any register
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        dir_t               dir;
    } speed_dir_t;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts speed and direction and holds the predictions
    // ------------------------------------------------------------------------
    class speed_scoreboard;
        logic [TURN_BITS_W-1:0] turn_bits;
        logic [PERIOD_W-1:0]    period;
        logic [DEAD_BAND_W-1:0] dead_band;
        bit                     primed;
        logic [31:0]            stored_position;
        dir_t                   last_class;
        dir_t                   held_dir;
        int unsigned            run_length;
        logic [SPEED_W-1:0]     rpm_history [HIST_DEPTH];
        int unsigned            slot;
        speed_dir_t             expected_q [$];
        int unsigned            errors;

        function new();
            turn_bits       = TURN_BITS_W'(TURN_BITS_RST);
            period          = PERIOD_W'(PERIOD_RST);
            dead_band       = DEAD_BAND_W'(DEAD_BAND_RST);
            primed          = 1'b0;
            stored_position = '0;
            last_class      = DIR_STOP;
            held_dir        = DIR_STOP;
            run_length      = 0;
            foreach (rpm_history[i])
                rpm_history[i] = '0;
            slot            = 0;
            errors          = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TURN_BITS: turn_bits = data[TURN_BITS_W-1:0];
                REG_PERIOD:    period    = data[PERIOD_W-1:0];
                REG_DEAD_BAND: dead_band = data[DEAD_BAND_W-1:0];
                default:       ;
            endcase
        endfunction

        // Resolution in use after clamping
        function int unsigned active_bits();
            int unsigned b;
            b = 32'(turn_bits);
            if (b < 1)
                b = 1;
            if (b > 32)
                b = 32;
            if (b > POSITION_WIDTH_DEF)
                b = POSITION_WIDTH_DEF;
            return b;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // Works out the result of one accepted position beat
        function void note_position(logic [IN_TDATA_W-1:0] pos);
            longint unsigned span, msk, half_span, cur, prv, mag, rpm;
            longint          delta;
            int unsigned     per;
            int              a, b, c, hi, lo;
            dir_t            cls;
            speed_dir_t      res;

            span      = 64'd1 << active_bits();
            msk       = span - 1;
            half_span = span >> 1;
            cur       = longint'(pos) & msk;
            prv       = longint'(stored_position) & msk;

            // Priming beat: store the position only
            if (!primed)
            begin
                stored_position = cur[31:0];
                primed          = 1'b1;
                held_dir        = DIR_STOP;
                res.speed       = '0;
                res.dir         = DIR_STOP;
                expected_q.push_back(res);
                return;
            end

            // Difference wrapped into plus or minus half a turn
            delta = longint'(cur) - longint'(prv);
            if (delta > longint'(half_span))
                delta = delta - longint'(span);
            else if (delta < -longint'(half_span))
                delta = delta + longint'(span);

            // Dead band classification and direction qualification
            if (delta > longint'(dead_band))
                cls = DIR_CW;
            else if (delta < -longint'(dead_band))
                cls = DIR_CCW;
            else
                cls = DIR_STOP;
            if (cls == last_class)
            begin
                if (run_length < CONFIRM_COUNT_DEF)
                    run_length++;
            end
            else
                run_length = 0;
            if (run_length >= CONFIRM_COUNT_DEF)
                held_dir = cls;
            last_class = cls;

            // Raw speed in rpm
            mag = (delta >= 0) ? longint'(delta) : longint'(-delta);
            per = 32'(period);
            if (per < 1 || per > PERIOD_MAX)
                per = 1;
            rpm = (mag * MS_PER_MIN) / (longint'(per) * TENS_MS * span);
            if (rpm > RPM_MAX)
                rpm = RPM_MAX;

            rpm_history[slot] = rpm[SPEED_W-1:0];
            slot = (slot + 1) % HIST_DEPTH;
            stored_position = cur[31:0];

            // Median of the three history entries
            a  = 32'(rpm_history[0]);
            b  = 32'(rpm_history[1]);
            c  = 32'(rpm_history[2]);
            hi = a;
            lo = a;
            if (b > hi) hi = b;
            if (c > hi) hi = c;
            if (b < lo) lo = b;
            if (c < lo) lo = c;
            res.speed = SPEED_W'(a + b + c - hi - lo);
            res.dir   = held_dir;
            expected_q.push_back(res);
        endfunction

        // Compares one result beat with the oldest prediction
        function void check_result(logic [OUT_TDATA_W-1:0] beat);
            speed_dir_t           exp_res;
            logic [SPEED_W-1:0]   got_speed;
            logic [DIR_W-1:0]     got_dir;
            logic [OUT_TDATA_W-SPEED_W-DIR_W-1:0] got_pad;

            if (expected_q.size() == 0)
            begin
                $error("result beat 0x%0h arrived with no prediction waiting", beat);
                errors++;
                return;
            end
            exp_res   = expected_q.pop_front();
            got_speed = beat[SPEED_W-1:0];
            got_dir   = beat[SPEED_W +: DIR_W];
            got_pad   = beat[OUT_TDATA_W-1:SPEED_W+DIR_W];
            if (got_speed !== exp_res.speed)
            begin
                $error("speed_rpm mismatch: expected %0d, actual %0d", exp_res.speed, got_speed);
                errors++;
            end
            if (got_dir !== exp_res.dir)
            begin
                $error("rot_dir mismatch: expected %0d, actual %0d", exp_res.dir, got_dir);
                errors++;
            end
            if (got_pad !== '0)
            begin
                $error("tdata padding mismatch: expected 0, actual %0d", got_pad);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;

    speed_scoreboard sb;
    int unsigned     send_idle_pct = 0;
    int unsigned     recv_idle_pct = 0;
    int unsigned     quiet_cycles  = 0;
    longint unsigned track         = 0;

    // ------------------------------------------------------------------------
    // Clock and device under test
    // ------------------------------------------------------------------------
    always #(CLK_HALF) clk = ~clk;

    encoder_speed_direction_estimator_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Receiver back-pressure
    // ------------------------------------------------------------------------
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // ------------------------------------------------------------------------
    // Monitors of the three channels
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_position(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: counts cycles in which no beat is taken on any channel
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------
    task automatic send_position(input logic [IN_TDATA_W-1:0] pos);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pos;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
    endtask

    // Leaves cfg_valid high; the caller lowers it after its last write
    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] tb_val,
                             input logic [CFG_DATA_W-1:0] per_val,
                             input logic [CFG_DATA_W-1:0] db_val);
        cfg_write(REG_TURN_BITS, tb_val);
        cfg_write(REG_PERIOD, per_val);
        cfg_write(REG_DEAD_BAND, db_val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Waits until every prediction has been met and the block has gone quiet
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random register settings, extremes and out-of-range values included
    task automatic configure_random();
        logic [CFG_DATA_W-1:0] tb_val, per_val, db_val;
        int unsigned           r;

        r = $urandom_range(0, 9);
        if (r < 7)
            tb_val = CFG_DATA_W'($urandom_range(1, 32));
        else if (r == 7)
            tb_val = '0;
        else if (r == 8)
            tb_val = CFG_DATA_W'($urandom_range(33, 63));
        else
            tb_val = CFG_DATA_W'($urandom());

        r = $urandom_range(0, 9);
        if (r < 7)
            per_val = CFG_DATA_W'($urandom_range(1, PERIOD_MAX));
        else if (r == 7)
            per_val = '0;
        else if (r == 8)
            per_val = CFG_DATA_W'($urandom_range(PERIOD_MAX + 1, 31));
        else
            per_val = CFG_DATA_W'($urandom());

        r = $urandom_range(0, 19);
        if (r < 8)
            db_val = CFG_DATA_W'($urandom_range(0, 8));
        else if (r < 14)
            db_val = CFG_DATA_W'($urandom_range(0, 255));
        else if (r < 17)
            db_val = CFG_DATA_W'($urandom());
        else if (r == 17)
            db_val = '0;
        else if (r == 18)
            db_val = 16'hFFFF;
        else
            db_val = CFG_DATA_W'(DEAD_BAND_RST);

        if ($urandom_range(0, 7) == 0)
            cfg_write(REG_UNUSED, CFG_DATA_W'($urandom()));
        configure(tb_val, per_val, db_val);
    endtask

    // Random motion: steady runs with jitter, reversals and plain noise
    task automatic run_random(input int count);
        longint unsigned span, msk, half_span, mag;
        longint          stride;
        logic [31:0]     msk32, pos;
        int              seg_left, seg_kind, r;

        span      = 64'd1 << sb.active_bits();
        msk       = span - 1;
        half_span = span >> 1;
        msk32     = msk[31:0];
        seg_left  = 0;
        seg_kind  = 0;
        stride    = 0;
        for (int i = 0; i < count; i++)
        begin
            if (seg_left == 0)
            begin
                seg_kind = $urandom_range(0, 9);
                r = $urandom_range(0, 9);
                if (r < 3)
                    mag = 64'($urandom_range(0, sb.dead_band));
                else if (r < 5)
                    mag = longint'(sb.dead_band) + 64'($urandom_range(1, 16));
                else if (r < 9)
                    mag = 64'($urandom_range(0, half_span[31:0]));
                else
                    mag = half_span;
                stride = $urandom_range(0, 1) ? longint'(mag) : -longint'(mag);
                if (seg_kind < 6)
                    seg_left = $urandom_range(4, 16);
                else if (seg_kind < 8)
                    seg_left = $urandom_range(1, 4);
                else
                    seg_left = $urandom_range(2, 8);
            end
            seg_left--;

            if (seg_kind < 6)
            begin
                // Steady motion, jittered now and then
                if ($urandom_range(0, 1))
                    track = (track + stride + $signed($urandom_range(0, 2)) - 1) & msk;
                else
                    track = (track + stride) & msk;
            end
            else if (seg_kind < 8)
                track = {$urandom()} & msk;
            else
            begin
                // Reversal on every beat
                stride = -stride;
                track  = (track + stride) & msk;
            end
            pos = (track[31:0] & msk32) | ($urandom() & ~msk32);
            send_position(pos);
        end
    endtask

    task automatic run_phase(input int count);
        int done, n;
        done = 0;
        while (done < count)
        begin
            wait_drained();
            configure_random();
            n = $urandom_range(40, 90);
            if (n > count - done)
                n = count - done;
            run_random(n);
            done += n;
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        send_idle_pct = 10;
        recv_idle_pct = 45;

        // Reset settings: priming, half-turn edges, dead band edges, runs
        send_position(32'h0000_0000);
        send_position(32'h0000_07FF);
        send_position(32'hFFFF_FFFF);
        send_position(32'h0000_07FF);
        send_position(32'h0000_0800);
        send_position(32'h0000_0802);
        send_position(32'h0000_0805);
        for (int i = 1; i <= 4; i++)
            send_position(32'h0000_0805 + 100 * i);
        for (int i = 1; i <= 4; i++)
            send_position(32'h0000_0995 - 100 * i);

        // Full resolution, longest period, widest dead band
        wait_drained();
        configure(16'd32, CFG_DATA_W'(PERIOD_MAX), 16'hFFFF);
        send_position(32'h0000_0000);
        send_position(32'h8000_0000);
        send_position(32'h0000_0000);
        send_position(32'hFFFF_FFFF);

        // Resolution and period below range, no dead band
        wait_drained();
        configure(16'd0, 16'd0, 16'd0);
        send_position(32'h0000_0001);
        send_position(32'h0000_0000);
        send_position(32'hFFFF_FFFF);

        // Resolution and period above range, written with all data bits set
        wait_drained();
        cfg_write(REG_UNUSED, 16'hA5A5);
        configure(16'hFFFF, 16'hFFFF, 16'd0);
        send_position(32'h0001_0000);
        send_position(32'hFFFF_0000);

        // Resolution changed between samples
        wait_drained();
        configure(16'd16, 16'd3, 16'd1);
        send_position(32'hABCD_FFFF);
        wait_drained();
        configure(16'd8, 16'd3, 16'd1);
        send_position(32'h0000_0001);

        // Random part under three back-pressure settings
        run_phase(PHASE_ITEMS);
        send_idle_pct = 45;
        recv_idle_pct = 10;
        run_phase(PHASE_ITEMS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(PHASE_ITEMS);

        wait_drained();
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
src/esde_pkg.sv
src/esde_serial_div.sv
src/encoder_speed_direction_estimator_core.sv
tb/tb_top.sv
